[sv/sh_l2_irradiance_accumulate_assert.svh]
// Assertion macros shared by the irradiance accumulator.
`ifndef SH_L2_IRRADIANCE_ACCUMULATE_ASSERT_SVH
`define SH_L2_IRRADIANCE_ACCUMULATE_ASSERT_SVH

// The consequence must hold in the same cycle as the condition.
`define SHIRR_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequence must hold in the cycle after the condition.
`define SHIRR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/shirr_pkg.sv]
`default_nettype none

package shirr_pkg;

    // Default coefficient width (signed Q(N-25).24).
    localparam int COEFF_BITS_DEF = 48;

    // Coefficient index sequencing.
    localparam int NUM_IDX = 9;
    localparam int IDX_W   = 4;
    localparam logic [IDX_W-1:0] IDX_B0 = 4'd0;
    localparam logic [IDX_W-1:0] IDX_B1 = 4'd1;
    localparam logic [IDX_W-1:0] IDX_B2 = 4'd2;
    localparam logic [IDX_W-1:0] IDX_B3 = 4'd3;
    localparam logic [IDX_W-1:0] IDX_B4 = 4'd4;
    localparam logic [IDX_W-1:0] IDX_B5 = 4'd5;
    localparam logic [IDX_W-1:0] IDX_B6 = 4'd6;
    localparam logic [IDX_W-1:0] IDX_B7 = 4'd7;
    localparam logic [IDX_W-1:0] IDX_B8 = 4'd8;

    // Request kinds.
    localparam logic KIND_ACC  = 1'b0;
    localparam logic KIND_EVAL = 1'b1;

    // Basis constants in Q.16.
    localparam logic signed [17:0] K_C0 = 18'sd18487;
    localparam logic signed [17:0] K_C1 = 18'sd32021;
    localparam logic signed [17:0] K_C2 = 18'sd71601;
    localparam logic signed [17:0] K_C3 = 18'sd20670;
    localparam logic signed [17:0] K_C4 = 18'sd35801;

    // Cosine lobe band weights in Q.16.
    localparam logic signed [16:0] K_BAND1 = 17'sd43691;
    localparam logic signed [16:0] K_BAND2 = 17'sd16384;

    // Datapath widths.
    localparam int P_W   = 36;  // polynomial term, Q.28
    localparam int Q_W   = 54;  // constant times polynomial, Q.44
    localparam int B_W   = 20;  // basis value, signed Q.16
    localparam int MAG_W = 19;  // magnitude of basis or weight
    localparam int RS_W  = 32;  // radiance times solid angle
    localparam int M_W   = 51;  // increment before rounding, Q.40
    localparam int D_W   = 35;  // increment magnitude, Q.24
    localparam int WP_W  = 37;  // basis times band weight, Q.32
    localparam int PP_W  = 51;  // partial product of evaluate term
    localparam int ACC_W = 64;  // irradiance sum, Q.16

    typedef struct packed {
        logic              kind;
        logic signed [15:0] vec_x;
        logic signed [15:0] vec_y;
        logic signed [15:0] vec_z;
        logic [15:0]       radiance_r;
        logic [15:0]       radiance_g;
        logic [15:0]       radiance_b;
        logic [15:0]       sample_weight;
    } in_t;

    typedef struct packed {
        logic [31:0] irr_r;
        logic [31:0] irr_g;
        logic [31:0] irr_b;
        logic        overflow;
    } out_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic             load;
        logic             issue;
        logic [IDX_W-1:0] idx;
        logic             finish;
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic busy;
        logic kind;
        logic out_free;
    } sts_t;

    // Basis constant for each coefficient index.
    function automatic logic signed [17:0] basis_k(input logic [IDX_W-1:0] idx);
        logic signed [17:0] k;
        case (idx)
            IDX_B0: k = K_C0;
            IDX_B1: k = K_C1;
            IDX_B2: k = K_C1;
            IDX_B3: k = K_C1;
            IDX_B4: k = K_C2;
            IDX_B5: k = K_C2;
            IDX_B6: k = K_C3;
            IDX_B7: k = K_C2;
            IDX_B8: k = K_C4;
            default: k = '0;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

[sv/sh_l2_irradiance_accumulate.sv]
// Accumulate request: the nine indices are issued, the pipeline drains, then the next request is accepted.
// Evaluate request: after the drain the result is loaded once the output register is free, then the next request.
// The nine coefficient indices pass one per cycle through a shared basis/multiply pipeline.
// The result register lets a new request start while a result waits to be taken.
// Reset (aresetn low, synchronous) clears all coefficients and empties the pipeline.
`default_nettype none

`include "sh_l2_irradiance_accumulate_assert.svh"

module sh_l2_irradiance_accumulate #(
    parameter int COEFF_BITS = shirr_pkg::COEFF_BITS_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire shirr_pkg::in_t s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output shirr_pkg::out_t     m_data
);

    shirr_pkg::cmd_t cmd;
    shirr_pkg::sts_t sts;

    // Sequencer.
    shirr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Basis, coefficient store and irradiance datapath.
    shirr_dp #(
        .COEFF_BITS (COEFF_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

    // One request at a time is in flight.
    `SHIRR_ASSERT_NEXT(a_one_request, aclk, aresetn, s_valid && s_ready, !s_ready, "request accepted while busy")
    // A result is only loaded when the output register is free.
    `SHIRR_ASSERT_SAME(a_finish_free, aclk, aresetn, cmd.finish, !m_valid || m_ready, "result overwritten")
    // Index issue never overlaps acceptance or result loading.
    `SHIRR_ASSERT_SAME(a_issue_excl, aclk, aresetn, cmd.issue, !s_ready && !cmd.finish, "issue overlap")

endmodule

`default_nettype wire

[sv/shirr_ctrl.sv]
`default_nettype none

module shirr_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire shirr_pkg::sts_t sts,
    output shirr_pkg::cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]                  state_reg, state_next;
    logic [shirr_pkg::IDX_W-1:0] cnt_reg, cnt_next;

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        cmd.idx    = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = ST_ISSUE;
                    cnt_next   = shirr_pkg::IDX_B0;
                end
            end
            ST_ISSUE: begin
                cmd.issue = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == shirr_pkg::IDX_B8) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!sts.busy) begin
                    state_next = (sts.kind == shirr_pkg::KIND_EVAL) ? ST_DONE : ST_IDLE;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

[sv/shirr_dp.sv]
`default_nettype none

module shirr_dp #(
    parameter int COEFF_BITS = shirr_pkg::COEFF_BITS_DEF
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire shirr_pkg::in_t  s_data,
    input  wire shirr_pkg::cmd_t cmd,
    output shirr_pkg::sts_t      sts,
    input  wire logic            m_ready,
    output logic                 m_valid,
    output shirr_pkg::out_t      m_data
);

    localparam int P_W   = shirr_pkg::P_W;
    localparam int Q_W   = shirr_pkg::Q_W;
    localparam int B_W   = shirr_pkg::B_W;
    localparam int MAG_W = shirr_pkg::MAG_W;
    localparam int RS_W  = shirr_pkg::RS_W;
    localparam int M_W   = shirr_pkg::M_W;
    localparam int D_W   = shirr_pkg::D_W;
    localparam int WP_W  = shirr_pkg::WP_W;
    localparam int PP_W  = shirr_pkg::PP_W;
    localparam int ACC_W = shirr_pkg::ACC_W;
    localparam int IDX_W = shirr_pkg::IDX_W;
    localparam int SUM_W = ((COEFF_BITS > D_W) ? COEFF_BITS : D_W) + 2;

    localparam logic signed [P_W-1:0]   P_ONE = P_W'(1) <<< 28;
    localparam logic signed [SUM_W-1:0] C_MAX = (SUM_W'(1) <<< (COEFF_BITS - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] C_MIN = -C_MAX - SUM_W'(1);
    localparam logic signed [ACC_W-1:0] IRR_MAX = ACC_W'(33'h0_FFFF_FFFF);

    // Captured request and per-channel radiance times solid angle.
    shirr_pkg::in_t in_reg;
    logic [RS_W-1:0] rs_reg [0:2];

    // Coefficient store: one row per index, one column per channel.
    logic signed [COEFF_BITS-1:0] coef_reg [0:8][0:2];

    // Pipeline valid bits and index tags.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic [IDX_W-1:0] idx1_reg, idx2_reg, idx3_reg, idx4_reg;

    logic signed [P_W-1:0]  p_reg;
    logic signed [Q_W-1:0]  q_reg;
    logic signed [B_W-1:0]  b_reg;
    logic [M_W-1:0]         mprod_reg [0:2];
    logic                   bneg4_reg;
    logic signed [WP_W-1:0] wp_reg;
    logic [MAG_W-1:0]       wm_reg;
    logic [COEFF_BITS-1:0]  cm_reg [0:2];
    logic                   tneg5_reg [0:2];
    logic [PP_W-1:0]        plo_reg [0:2];
    logic [PP_W-1:0]        phi_reg [0:2];
    logic                   tneg6_reg [0:2];
    logic signed [ACC_W-1:0] acc_reg [0:2];
    logic                   m_valid_reg;
    shirr_pkg::out_t        m_data_reg;

    // Polynomial stage: one multiplier selects its operands by index.
    logic signed [17:0]    op_a, op_b;
    logic signed [P_W-1:0] prod, p_next;

    assign prod = P_W'(op_a) * P_W'(op_b);

    always_comb begin
        op_a   = '0;
        op_b   = '0;
        p_next = '0;
        case (cmd.idx)
            shirr_pkg::IDX_B0: p_next = P_ONE;
            shirr_pkg::IDX_B1: p_next = P_W'(in_reg.vec_y) <<< 14;
            shirr_pkg::IDX_B2: p_next = P_W'(in_reg.vec_z) <<< 14;
            shirr_pkg::IDX_B3: p_next = P_W'(in_reg.vec_x) <<< 14;
            shirr_pkg::IDX_B4: begin
                op_a   = 18'(in_reg.vec_x);
                op_b   = 18'(in_reg.vec_y);
                p_next = prod;
            end
            shirr_pkg::IDX_B5: begin
                op_a   = 18'(in_reg.vec_y);
                op_b   = 18'(in_reg.vec_z);
                p_next = prod;
            end
            shirr_pkg::IDX_B6: begin
                op_a   = 18'(in_reg.vec_z);
                op_b   = 18'(in_reg.vec_z) + 18'(in_reg.vec_z) + 18'(in_reg.vec_z);
                p_next = prod - P_ONE;
            end
            shirr_pkg::IDX_B7: begin
                op_a   = 18'(in_reg.vec_x);
                op_b   = 18'(in_reg.vec_z);
                p_next = prod;
            end
            shirr_pkg::IDX_B8: begin
                op_a   = 18'(in_reg.vec_x) + 18'(in_reg.vec_y);
                op_b   = 18'(in_reg.vec_x) - 18'(in_reg.vec_y);
                p_next = prod;
            end
            default: p_next = '0;
        endcase
    end

    // Constant multiply stage.
    logic signed [Q_W-1:0] q_next;
    assign q_next = Q_W'(shirr_pkg::basis_k(idx1_reg)) * Q_W'(p_reg);

    // Round the basis value to Q.16, half away from zero.
    logic [Q_W-1:0]       q_mag, q_rnd;
    logic [B_W-1:0]       b_mag;
    logic signed [B_W-1:0] b_next;
    always_comb begin
        q_mag  = q_reg[Q_W-1] ? Q_W'(-q_reg) : Q_W'(q_reg);
        q_rnd  = q_mag + (Q_W'(1) << 27);
        b_mag  = q_rnd[28 +: B_W];
        b_next = q_reg[Q_W-1] ? -$signed(b_mag) : $signed(b_mag);
    end

    // Accumulate increment product and band weight product.
    logic [MAG_W-1:0]       bm3;
    logic signed [WP_W-1:0] wp_next;
    always_comb begin
        bm3 = b_reg[B_W-1] ? MAG_W'(-b_reg) : MAG_W'(b_reg);
        if (idx3_reg == shirr_pkg::IDX_B0) begin
            wp_next = WP_W'(b_reg) <<< 16;
        end else if (idx3_reg inside {shirr_pkg::IDX_B1, shirr_pkg::IDX_B2,
                                      shirr_pkg::IDX_B3}) begin
            wp_next = WP_W'(b_reg) * WP_W'(shirr_pkg::K_BAND1);
        end else begin
            wp_next = WP_W'(b_reg) * WP_W'(shirr_pkg::K_BAND2);
        end
    end

    // Weight rounding to Q.16.
    logic [WP_W-1:0]  wp_mag, wp_rnd;
    logic [MAG_W-1:0] wm_next;
    always_comb begin
        wp_mag  = wp_reg[WP_W-1] ? WP_W'(-wp_reg) : WP_W'(wp_reg);
        wp_rnd  = wp_mag + (WP_W'(1) << 15);
        wm_next = wp_rnd[16 +: MAG_W];
    end

    // Per-channel saturating update, coefficient magnitude and term assembly.
    logic [M_W-1:0]           d_rnd [0:2];
    logic [D_W-1:0]           d_mag [0:2];
    logic signed [SUM_W-1:0]  d_ext [0:2];
    logic signed [SUM_W-1:0]  c_sum [0:2];
    logic signed [COEFF_BITS-1:0] c_next [0:2];
    logic signed [COEFF_BITS-1:0] c_rd [0:2];
    logic [COEFF_BITS-1:0]    cm_next [0:2];
    logic [63:0]              cm_pad [0:2];
    logic [ACC_W-1:0]         t_mag [0:2];
    logic signed [ACC_W-1:0]  t_val [0:2];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            c_rd[c]  = coef_reg[idx4_reg][c];
            d_rnd[c] = mprod_reg[c] + (M_W'(1) << 15);
            d_mag[c] = d_rnd[c][16 +: D_W];
            d_ext[c] = bneg4_reg ? -SUM_W'({1'b0, d_mag[c]}) : SUM_W'({1'b0, d_mag[c]});
            c_sum[c] = SUM_W'(c_rd[c]) + d_ext[c];
            if (c_sum[c] > C_MAX) begin
                c_next[c] = $signed(C_MAX[COEFF_BITS-1:0]);
            end else if (c_sum[c] < C_MIN) begin
                c_next[c] = $signed(C_MIN[COEFF_BITS-1:0]);
            end else begin
                c_next[c] = $signed(c_sum[c][COEFF_BITS-1:0]);
            end
            cm_next[c] = c_rd[c][COEFF_BITS-1] ? COEFF_BITS'(-c_rd[c]) : COEFF_BITS'(c_rd[c]);
            cm_pad[c]  = 64'(cm_reg[c]);
            t_mag[c]   = (ACC_W'(phi_reg[c]) << 8)
                       + ACC_W'((plo_reg[c] + (PP_W'(1) << 23)) >> 24);
            t_val[c]   = tneg6_reg[c] ? -$signed(t_mag[c]) : $signed(t_mag[c]);
        end
    end

    // Output clamp.
    shirr_pkg::out_t out_next;
    logic [31:0]     irr [0:2];
    logic [2:0]      ovf;
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            ovf[c] = 1'b0;
            if (acc_reg[c] < 0) begin
                irr[c] = '0;
            end else if (acc_reg[c] > IRR_MAX) begin
                irr[c] = '1;
                ovf[c] = 1'b1;
            end else begin
                irr[c] = acc_reg[c][31:0];
            end
        end
        out_next.irr_r    = irr[0];
        out_next.irr_g    = irr[1];
        out_next.irr_b    = irr[2];
        out_next.overflow = |ovf;
    end

    // Control registers: pipeline valid bits and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            v6_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg && (in_reg.kind == shirr_pkg::KIND_EVAL);
            v6_reg <= v5_reg;
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Coefficient store, cleared at reset and updated by accumulate requests.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < shirr_pkg::NUM_IDX; i++) begin
                for (int c = 0; c < 3; c++) begin
                    coef_reg[i][c] <= '0;
                end
            end
        end else if (v4_reg && (in_reg.kind == shirr_pkg::KIND_ACC)) begin
            for (int c = 0; c < 3; c++) begin
                coef_reg[idx4_reg][c] <= c_next[c];
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_reg <= s_data;
        end
        rs_reg[0] <= in_reg.radiance_r * in_reg.sample_weight;
        rs_reg[1] <= in_reg.radiance_g * in_reg.sample_weight;
        rs_reg[2] <= in_reg.radiance_b * in_reg.sample_weight;
        idx1_reg  <= cmd.idx;
        idx2_reg  <= idx1_reg;
        idx3_reg  <= idx2_reg;
        idx4_reg  <= idx3_reg;
        p_reg     <= p_next;
        q_reg     <= q_next;
        b_reg     <= b_next;
        bneg4_reg <= b_reg[B_W-1];
        wp_reg    <= wp_next;
        wm_reg    <= wm_next;
        for (int c = 0; c < 3; c++) begin
            mprod_reg[c] <= M_W'(rs_reg[c]) * M_W'(bm3);
            cm_reg[c]    <= cm_next[c];
            tneg5_reg[c] <= c_rd[c][COEFF_BITS-1] ^ wp_reg[WP_W-1];
            plo_reg[c]   <= PP_W'(cm_pad[c][31:0]) * PP_W'(wm_reg);
            phi_reg[c]   <= PP_W'(cm_pad[c][63:32]) * PP_W'(wm_reg);
            tneg6_reg[c] <= tneg5_reg[c];
            if (cmd.load) begin
                acc_reg[c] <= '0;
            end else if (v6_reg) begin
                acc_reg[c] <= acc_reg[c] + t_val[c];
            end
        end
        if (cmd.finish) begin
            m_data_reg <= out_next;
        end
    end

    assign sts.busy     = v1_reg | v2_reg | v3_reg | v4_reg | v5_reg | v6_reg;
    assign sts.kind     = in_reg.kind;
    assign sts.out_free = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;
    assign m_data       = m_data_reg;

endmodule

`default_nettype wire
